// ----- sv/lsbc_pkg.sv -----
// Shared types and constants for the LED status blink controller.
// No dependencies; used by lsbc_chan and led_status_blink_controller_top.
`default_nettype none

package lsbc_pkg;

    localparam int NUM_CH     = 3;
    localparam int CNT_W      = 16;   // countdown, phase and period width
    localparam int DUTY_W     = 9;    // duty in 1/256 units, 0..511 (256 and above: always high)
    localparam int MODE_W     = 3;
    localparam int DIR_W      = 3;
    localparam int MAG_W      = 2;
    localparam int CFG_IDX_W  = 4;    // room for unlisted indexes, which are ignored
    localparam int CFG_DATA_W = 16;

    localparam int TICK_MS_DEF = 5;

    // Register reset values
    localparam logic [CNT_W-1:0]  RST_DURATION = 16'd400;
    localparam logic [CNT_W-1:0]  RST_PERIOD_A = 16'd200;
    localparam logic [CNT_W-1:0]  RST_PERIOD_B = 16'd500;
    localparam logic [CNT_W-1:0]  RST_PERIOD_C = 16'd800;
    localparam logic [DUTY_W-1:0] RST_DUTY     = 9'd128;
    localparam logic [NUM_CH-1:0] RST_ENDLESS  = 3'd0;

    typedef enum logic [CFG_IDX_W-1:0] {
        CFG_DURATION = 4'd0,
        CFG_PERIOD_A = 4'd1,
        CFG_PERIOD_B = 4'd2,
        CFG_PERIOD_C = 4'd3,
        CFG_DUTY_A   = 4'd4,
        CFG_DUTY_B   = 4'd5,
        CFG_DUTY_C   = 4'd6,
        CFG_ENDLESS  = 4'd7
    } t_cfg_idx;

    typedef enum logic [MODE_W-1:0] {
        MODE_ALL_BLINK = 3'd0,
        MODE_DIR_CAL   = 3'd1,
        MODE_MAG_CAL   = 3'd2,
        MODE_ALL_HIGH  = 3'd3
    } t_mode;

    // Per-channel controls for one request
    typedef struct packed {
        logic load;      // start: load countdown, clear phase
        logic step;      // run one blink step
        logic force_hi;  // drive pin high
    } t_chan_ctl;

endpackage

`default_nettype wire

// ----- sv/lsbc_chan.sv -----
// One blink channel: countdown, phase counter and pin level registers.
// Depends on lsbc_pkg.
`default_nettype none

module lsbc_chan #(
    parameter int TICK_MS = lsbc_pkg::TICK_MS_DEF
) (
    input  wire                             i_clk,
    input  wire                             i_rst_n,
    input  lsbc_pkg::t_chan_ctl             i_ctl,
    input  wire [lsbc_pkg::CNT_W-1:0]       i_duration,
    input  wire [lsbc_pkg::CNT_W-1:0]       i_period,
    input  wire [lsbc_pkg::DUTY_W-1:0]      i_duty,
    input  wire                             i_endless,
    output logic                            o_pin,
    output logic                            o_pin_next
);

    localparam int TICK_W = $clog2(TICK_MS + 1);
    localparam int TP_W   = lsbc_pkg::CNT_W + TICK_W;
    localparam int LIM_W  = lsbc_pkg::CNT_W + lsbc_pkg::DUTY_W;
    localparam int LHS_W  = TP_W + 8;
    localparam int CMP_W  = (LHS_W > LIM_W) ? LHS_W : LIM_W;
    localparam logic [TICK_W-1:0] TICK_C = TICK_W'(TICK_MS);

    logic [lsbc_pkg::CNT_W-1:0] r_rem, n_rem;
    logic [lsbc_pkg::CNT_W-1:0] r_phase, n_phase;
    logic                       r_pin, n_pin;

    logic [lsbc_pkg::CNT_W-1:0] rem_dec;
    logic                       spent;
    logic                       run;
    logic [lsbc_pkg::CNT_W-1:0] ph_inc;
    logic [lsbc_pkg::CNT_W-1:0] ph_new;
    logic [TP_W-1:0]            tp;
    logic [TP_W-1:0]            tp_new;
    logic                       wrap;
    logic [LIM_W-1:0]           hi_lim;
    logic                       in_high;

    always_comb begin
        spent   = (r_rem == '0);
        rem_dec = spent ? r_rem : r_rem - 1'b1;
        run     = (rem_dec != '0) || i_endless;
        ph_inc  = r_phase + 1'b1;
        // phase time in ms; wraps once it reaches the period
        tp      = TP_W'(ph_inc) * TP_W'(TICK_C);
        wrap    = (tp >= TP_W'(i_period));
        ph_new  = wrap ? '0 : ph_inc;
        tp_new  = wrap ? '0 : tp;
        hi_lim  = LIM_W'(i_period) * LIM_W'(i_duty);
        in_high = (CMP_W'({tp_new, 8'h00}) <= CMP_W'(hi_lim));
    end

    always_comb begin
        n_rem   = r_rem;
        n_phase = r_phase;
        n_pin   = r_pin;
        if (i_ctl.load) begin
            n_rem   = i_duration;
            n_phase = '0;
        end else if (i_ctl.force_hi) begin
            n_pin = 1'b1;
        end else if (i_ctl.step) begin
            n_rem = rem_dec;
            if (spent) begin
                n_pin = 1'b1;
            end
            if (run) begin
                n_phase = ph_new;
                n_pin   = in_high;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_rem   <= '0;
            r_phase <= '0;
            r_pin   <= 1'b0;
        end else begin
            r_rem   <= n_rem;
            r_phase <= n_phase;
            r_pin   <= n_pin;
        end
    end

    assign o_pin      = r_pin;
    assign o_pin_next = n_pin;

endmodule

`default_nettype wire

// ----- sv/led_status_blink_controller_top.sv -----
// LED status blink controller: a request passes the input register, then the result register,
// and the result is held there until the result side takes it; a stall on the result side
// holds the request in the input register. Throughput one request per cycle while the result
// side does not stall; the channel step is one pass of compare/multiply logic between them.
// Reset (i_rst_n low, synchronous) clears countdowns, phases, pins and valids and
// loads the configuration registers with their defaults.
// Depends on lsbc_pkg and lsbc_chan.
`default_nettype none

module led_status_blink_controller_top #(
    parameter int TICK_MS = lsbc_pkg::TICK_MS_DEF
) (
    input  wire                               i_clk,
    input  wire                               i_rst_n,
    // request channel
    input  wire                               i_in_valid,
    output logic                              o_in_stall,
    input  wire                               i_command,
    input  wire [lsbc_pkg::MODE_W-1:0]        i_display_mode,
    input  wire [lsbc_pkg::DIR_W-1:0]         i_calib_direction,
    input  wire [lsbc_pkg::MAG_W-1:0]         i_mag_step,
    // result channel
    output logic                              o_out_valid,
    input  wire                               i_out_stall,
    output logic                              o_led_1,
    output logic                              o_led_2,
    output logic                              o_led_3,
    // configuration write channel
    input  wire                               i_cfg_valid,
    output logic                              o_cfg_ready,
    input  wire [lsbc_pkg::CFG_IDX_W-1:0]     i_cfg_index,
    input  wire [lsbc_pkg::CFG_DATA_W-1:0]    i_cfg_data
);

    localparam int NCH = lsbc_pkg::NUM_CH;

    // ---------------- configuration registers ----------------
    logic [lsbc_pkg::CNT_W-1:0]  r_duration;
    logic [lsbc_pkg::CNT_W-1:0]  r_period [NCH];
    logic [lsbc_pkg::DUTY_W-1:0] r_duty   [NCH];
    logic [NCH-1:0]              r_endless;

    assign o_cfg_ready = 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_duration <= lsbc_pkg::RST_DURATION;
            r_period[0] <= lsbc_pkg::RST_PERIOD_A;
            r_period[1] <= lsbc_pkg::RST_PERIOD_B;
            r_period[2] <= lsbc_pkg::RST_PERIOD_C;
            r_duty[0]  <= lsbc_pkg::RST_DUTY;
            r_duty[1]  <= lsbc_pkg::RST_DUTY;
            r_duty[2]  <= lsbc_pkg::RST_DUTY;
            r_endless  <= lsbc_pkg::RST_ENDLESS;
        end else if (i_cfg_valid && o_cfg_ready) begin
            unique case (lsbc_pkg::t_cfg_idx'(i_cfg_index))
                lsbc_pkg::CFG_DURATION: r_duration  <= i_cfg_data;
                lsbc_pkg::CFG_PERIOD_A: r_period[0] <= i_cfg_data;
                lsbc_pkg::CFG_PERIOD_B: r_period[1] <= i_cfg_data;
                lsbc_pkg::CFG_PERIOD_C: r_period[2] <= i_cfg_data;
                lsbc_pkg::CFG_DUTY_A:   r_duty[0]   <= i_cfg_data[lsbc_pkg::DUTY_W-1:0];
                lsbc_pkg::CFG_DUTY_B:   r_duty[1]   <= i_cfg_data[lsbc_pkg::DUTY_W-1:0];
                lsbc_pkg::CFG_DUTY_C:   r_duty[2]   <= i_cfg_data[lsbc_pkg::DUTY_W-1:0];
                lsbc_pkg::CFG_ENDLESS:  r_endless   <= i_cfg_data[NCH-1:0];
                default: ;  // unlisted index: ignored
            endcase
        end
    end

    // ---------------- input register ----------------
    // The result register frees up when empty or being taken; the input
    // register then hands its request through the channel step.
    logic                          r_in_valid;
    logic                          r_in_cmd;
    logic [lsbc_pkg::MODE_W-1:0]   r_in_mode;
    logic [lsbc_pkg::DIR_W-1:0]    r_in_dir;
    logic [lsbc_pkg::MAG_W-1:0]    r_in_mag;

    logic r_out_valid;
    logic [NCH-1:0] r_out_led;

    logic out_free;
    logic proc;
    logic in_take;

    assign out_free   = !r_out_valid || !i_out_stall;
    assign proc       = r_in_valid && out_free;
    assign o_in_stall = r_in_valid && !out_free;
    assign in_take    = i_in_valid && !o_in_stall;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (in_take) begin
            r_in_valid <= 1'b1;
        end else if (proc) begin
            r_in_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (in_take) begin
            r_in_cmd  <= i_command;
            r_in_mode <= i_display_mode;
            r_in_dir  <= i_calib_direction;
            r_in_mag  <= i_mag_step;
        end
    end

    // ---------------- channel selection ----------------
    // Direction calibration: faces map to channel masks 1..6; unknown faces blink all.
    // Magnetometer calibration: one channel per step; the last code blinks all.
    logic [NCH-1:0] sel;
    logic           mode_blink;
    logic           mode_high;

    always_comb begin
        sel = '1;
        unique case (r_in_mode)
            3'(lsbc_pkg::MODE_DIR_CAL): begin
                unique case (r_in_dir)
                    3'd0:    sel = 3'b001;
                    3'd1:    sel = 3'b010;
                    3'd2:    sel = 3'b011;
                    3'd3:    sel = 3'b100;
                    3'd4:    sel = 3'b101;
                    3'd5:    sel = 3'b110;
                    default: sel = 3'b111;
                endcase
            end
            3'(lsbc_pkg::MODE_MAG_CAL): begin
                unique case (r_in_mag)
                    2'd0:    sel = 3'b001;
                    2'd1:    sel = 3'b010;
                    2'd2:    sel = 3'b100;
                    default: sel = 3'b111;
                endcase
            end
            default: sel = '1;
        endcase
        mode_blink = (r_in_mode == 3'(lsbc_pkg::MODE_ALL_BLINK))
                  || (r_in_mode == 3'(lsbc_pkg::MODE_DIR_CAL))
                  || (r_in_mode == 3'(lsbc_pkg::MODE_MAG_CAL));
        mode_high  = (r_in_mode == 3'(lsbc_pkg::MODE_ALL_HIGH));
    end

    // ---------------- channels ----------------
    lsbc_pkg::t_chan_ctl ctl [NCH];
    logic [NCH-1:0] pin;
    logic [NCH-1:0] pin_next;

    for (genvar k = 0; k < NCH; k++) begin : g_ch
        always_comb begin
            ctl[k].load     = proc && r_in_cmd;
            ctl[k].step     = proc && !r_in_cmd && mode_blink && sel[k];
            ctl[k].force_hi = proc && !r_in_cmd
                           && ((mode_blink && !sel[k]) || mode_high);
        end

        lsbc_chan #(
            .TICK_MS (TICK_MS)
        ) u_chan (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_ctl      (ctl[k]),
            .i_duration (r_duration),
            .i_period   (r_period[k]),
            .i_duty     (r_duty[k]),
            .i_endless  (r_endless[k]),
            .o_pin      (pin[k]),
            .o_pin_next (pin_next[k])
        );
    end

    // ---------------- result register ----------------
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (proc) begin
            r_out_valid <= 1'b1;
        end else if (!i_out_stall) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (proc) begin
            r_out_led <= pin_next;
        end
    end

    assign o_out_valid = r_out_valid;
    assign o_led_1     = r_out_led[0];
    assign o_led_2     = r_out_led[1];
    assign o_led_3     = r_out_led[2];

    // ---------------- assertions ----------------
    // A processed request always leaves a result behind.
    a_proc_gives_result: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> r_out_valid)
        else $error("processed request produced no result");

    // Result register reports the pin state the channels now hold.
    a_result_matches_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        proc |=> (r_out_led == pin))
        else $error("result differs from channel pin state");

    // Start request leaves pin levels untouched.
    a_start_holds_pins: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && r_in_cmd) |=> (pin == $past(pin)))
        else $error("start request changed pin levels");

    // All-high mode drives every pin high.
    a_all_high: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (proc && !r_in_cmd && mode_high) |=> (pin == '1))
        else $error("all-high mode left a pin low");

endmodule

`default_nettype wire

// ----- dv/lsbc_tb_pkg.sv -----
`timescale 1ns / 100ps
// Scoreboard for the LED blink controller bench: pin-level prediction and result checks.
// Depends on lsbc_pkg for widths, register indexes, display modes and reset values.
package lsbc_tb_pkg;
    import lsbc_pkg::*;

    localparam logic CMD_TICK  = 1'b0;
    localparam logic CMD_START = 1'b1;
    localparam int   NUM_DIR   = 6;     // accelerometer calibration faces
    localparam int   NUM_MAG   = 3;     // magnetometer calibration steps
    localparam int   TICK_MS   = TICK_MS_DEF;

    class led_pin_scoreboard;
        logic [CNT_W-1:0]  duration;
        logic [CNT_W-1:0]  period    [NUM_CH];
        logic [DUTY_W-1:0] duty      [NUM_CH];
        logic [NUM_CH-1:0] endless;
        logic [CNT_W-1:0]  countdown [NUM_CH];
        logic [CNT_W-1:0]  phase     [NUM_CH];
        logic [NUM_CH-1:0] pins;
        logic [NUM_CH-1:0] expected_pins[$];
        int                errors;

        function new();
            duration  = RST_DURATION;
            period[0] = RST_PERIOD_A;
            period[1] = RST_PERIOD_B;
            period[2] = RST_PERIOD_C;
            endless   = RST_ENDLESS;
            pins      = '0;
            errors    = 0;
            for (int ch = 0; ch < NUM_CH; ch++) begin
                duty[ch]      = RST_DUTY;
                countdown[ch] = '0;
                phase[ch]     = '0;
            end
        endfunction

        function void write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_DATA_W-1:0] data);
            case (idx)
                CFG_DURATION: duration  = data;
                CFG_PERIOD_A: period[0] = data;
                CFG_PERIOD_B: period[1] = data;
                CFG_PERIOD_C: period[2] = data;
                CFG_DUTY_A:   duty[0]   = data[DUTY_W-1:0];
                CFG_DUTY_B:   duty[1]   = data[DUTY_W-1:0];
                CFG_DUTY_C:   duty[2]   = data[DUTY_W-1:0];
                CFG_ENDLESS:  endless   = data[NUM_CH-1:0];
                default: ;  // unlisted index: dropped
            endcase
        endfunction

        // One blink step of a channel
        function void advance_channel(int ch);
            logic [63:0] hi_limit;
            if (countdown[ch] != 0)
                countdown[ch] = countdown[ch] - 1'b1;
            else
                pins[ch] = 1'b1;
            // the tick that spends the countdown takes no phase step unless the channel is endless
            if (countdown[ch] != 0 || endless[ch]) begin
                hi_limit  = 64'(period[ch]) * 64'(duty[ch]);
                phase[ch] = phase[ch] + 1'b1;
                if (64'(TICK_MS) * 64'(phase[ch]) >= 64'(period[ch]))
                    phase[ch] = '0;
                pins[ch] = (64'(TICK_MS) * 64'(phase[ch]) * 64'd256 <= hi_limit);
            end
        endfunction

        function logic [NUM_CH-1:0] selected_channels(logic [MODE_W-1:0] mode,
                                                      logic [DIR_W-1:0] dir,
                                                      logic [MAG_W-1:0] mag);
            case (mode)
                // faces map to masks 1..6 in order; others blink all
                MODE_DIR_CAL: return (dir < NUM_DIR) ? NUM_CH'(dir + 1) : '1;
                MODE_MAG_CAL: return (mag < NUM_MAG) ? NUM_CH'(1 << mag) : '1;
                default:      return '1;
            endcase
        endfunction

        function void note_request(logic cmd, logic [MODE_W-1:0] mode,
                                   logic [DIR_W-1:0] dir, logic [MAG_W-1:0] mag);
            logic [NUM_CH-1:0] sel;
            if (cmd == CMD_START) begin
                for (int ch = 0; ch < NUM_CH; ch++) begin
                    countdown[ch] = duration;
                    phase[ch]     = '0;
                end
            end else begin
                case (mode)
                    MODE_ALL_BLINK, MODE_DIR_CAL, MODE_MAG_CAL: begin
                        sel = selected_channels(mode, dir, mag);
                        for (int ch = 0; ch < NUM_CH; ch++) begin
                            if (sel[ch])
                                advance_channel(ch);
                            else
                                pins[ch] = 1'b1;
                        end
                    end
                    MODE_ALL_HIGH: pins = '1;
                    default: ;  // hold modes
                endcase
            end
            expected_pins.push_back(pins);
        endfunction

        function void check_pins(logic [NUM_CH-1:0] got);
            logic [NUM_CH-1:0] want;
            if (expected_pins.size() == 0) begin
                $error("LED result %b with no request pending", got);
                errors++;
                return;
            end
            want = expected_pins.pop_front();
            for (int ch = 0; ch < NUM_CH; ch++) begin
                if (got[ch] !== want[ch]) begin
                    $error("led_%0d mismatch: expected %0b, got %0b", ch + 1, want[ch], got[ch]);
                    errors++;
                end
            end
        endfunction

        function int pending();
            return expected_pins.size();
        endfunction
    endclass

endpackage

// ----- dv/led_status_blink_controller_top_tb.sv -----
`timescale 1ns / 100ps
// Testbench top for led_status_blink_controller_top: drives requests and register writes,
// checks LED pins through led_pin_scoreboard. Depends on lsbc_pkg, lsbc_tb_pkg and the RTL.
module led_status_blink_controller_top_tb;
    import lsbc_pkg::*;
    import lsbc_tb_pkg::*;

    localparam int CYCLE_LIMIT     = 200000;  // watchdog bound for the whole run
    localparam int PHASES          = 8;
    localparam int ITEMS_PER_PHASE = 200;
    localparam int SETTLE_CYCLES   = 4;       // settle wait after draining, with margin

    logic                  i_clk;
    logic                  i_rst_n;
    logic                  i_in_valid;
    logic                  o_in_stall;
    logic                  i_command;
    logic [MODE_W-1:0]     i_display_mode;
    logic [DIR_W-1:0]      i_calib_direction;
    logic [MAG_W-1:0]      i_mag_step;
    logic                  o_out_valid;
    logic                  i_out_stall;
    logic                  o_led_1;
    logic                  o_led_2;
    logic                  o_led_3;
    logic                  i_cfg_valid;
    logic                  o_cfg_ready;
    logic [CFG_IDX_W-1:0]  i_cfg_index;
    logic [CFG_DATA_W-1:0] i_cfg_data;

    led_pin_scoreboard sb = new();
    bit                steady;       // set: neither side idles
    int unsigned       cycles;

    led_status_blink_controller_top dut (
        .i_clk             (i_clk),
        .i_rst_n           (i_rst_n),
        .i_in_valid        (i_in_valid),
        .o_in_stall        (o_in_stall),
        .i_command         (i_command),
        .i_display_mode    (i_display_mode),
        .i_calib_direction (i_calib_direction),
        .i_mag_step        (i_mag_step),
        .o_out_valid       (o_out_valid),
        .i_out_stall       (i_out_stall),
        .o_led_1           (o_led_1),
        .o_led_2           (o_led_2),
        .o_led_3           (o_led_3),
        .i_cfg_valid       (i_cfg_valid),
        .o_cfg_ready       (o_cfg_ready),
        .i_cfg_index       (i_cfg_index),
        .i_cfg_data        (i_cfg_data)
    );

    // 10 ns clock
    always begin
        i_clk = 1'b1;
        #5;
        i_clk = 1'b0;
        #5;
    end

    // Watchdog: a hung handshake ends the run here
    always @(posedge i_clk) begin
        cycles++;
        if (cycles > CYCLE_LIMIT) begin
            $display("*** FAILED ***");
            $finish;
        end
    end

    // Result side: random back-pressure, changed at the falling edge only
    always @(negedge i_clk)
        i_out_stall = !steady && ($urandom_range(99) < 10);

    // Every result taken at a rising edge is checked against the oldest prediction
    always @(posedge i_clk) begin
        if (i_rst_n && o_out_valid && !i_out_stall)
            sb.check_pins({o_led_3, o_led_2, o_led_1});
    end

    // One request; entered and left at a falling edge. Valid stays high between
    // back-to-back requests, and the payload holds while stalled.
    task automatic send_request(input logic cmd, input logic [MODE_W-1:0] mode,
                                input logic [DIR_W-1:0] dir, input logic [MAG_W-1:0] mag);
        if (!steady && $urandom_range(99) < 10) begin
            i_in_valid = 1'b0;
            repeat ($urandom_range(1, 2)) @(negedge i_clk);
        end
        i_in_valid        = 1'b1;
        i_command         = cmd;
        i_display_mode    = mode;
        i_calib_direction = dir;
        i_mag_step        = mag;
        do @(posedge i_clk); while (o_in_stall);
        sb.note_request(cmd, mode, dir, mag);
        @(negedge i_clk);
    endtask

    // Mostly ticks in the blinking modes; a few starts to re-arm the countdowns
    task automatic send_random_request();
        logic              cmd;
        logic [MODE_W-1:0] mode;
        cmd  = ($urandom_range(99) < 4) ? CMD_START : CMD_TICK;
        mode = ($urandom_range(99) < 80)
             ? MODE_W'($urandom_range(MODE_ALL_BLINK, MODE_MAG_CAL))
             : MODE_W'($urandom_range(MODE_ALL_HIGH, 2**MODE_W - 1));
        send_request(cmd, mode, DIR_W'($urandom_range(0, 2**DIR_W - 1)),
                     MAG_W'($urandom_range(0, 2**MAG_W - 1)));
    endtask

    // Stop sending and wait for every predicted result, then let the pipe settle
    task automatic wait_drained();
        i_in_valid = 1'b0;
        while (sb.pending() != 0) @(negedge i_clk);
        repeat (SETTLE_CYCLES) @(negedge i_clk);
    endtask

    task automatic write_cfg(input logic [CFG_IDX_W-1:0] idx,
                             input logic [CFG_DATA_W-1:0] data);
        i_cfg_valid = 1'b1;
        i_cfg_index = idx;
        i_cfg_data  = data;
        do @(posedge i_clk); while (!o_cfg_ready);
        sb.write_reg(idx, data);
        @(negedge i_clk);
        i_cfg_valid = 1'b0;
    endtask

    // Register set for one random phase. Phase 0 is all zeros (zero period, zero duty,
    // no countdown), phase 1 all ones (longest countdown and period, duty above 256,
    // all endless), phase 2 raw random words, phase 3 full duty; the rest use small
    // durations and periods so countdowns expire and phases wrap often.
    task automatic load_settings(input int p);
        logic [CFG_DATA_W-1:0] val;
        for (int r = int'(CFG_DURATION); r <= int'(CFG_ENDLESS); r++) begin
            case (t_cfg_idx'(r))
                CFG_DURATION: val = CFG_DATA_W'($urandom_range(0, 60));
                CFG_PERIOD_A, CFG_PERIOD_B, CFG_PERIOD_C:
                    val = CFG_DATA_W'($urandom_range(0, 400));
                CFG_DUTY_A, CFG_DUTY_B, CFG_DUTY_C:
                    val = (p == 3) ? CFG_DATA_W'(256)
                                   : CFG_DATA_W'($urandom_range(0, 300));
                default: val = CFG_DATA_W'($urandom_range(0, 2**NUM_CH - 1));
            endcase
            if (p == 0)
                val = '0;
            else if (p == 1)
                val = '1;
            else if (p == 2)
                val = CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1));
            write_cfg(CFG_IDX_W'(r), val);
        end
        // index beyond the register list: must change nothing
        if ($urandom_range(1))
            write_cfg(CFG_IDX_W'($urandom_range(int'(CFG_ENDLESS) + 1, 2**CFG_IDX_W - 1)),
                      CFG_DATA_W'($urandom_range(0, 2**CFG_DATA_W - 1)));
    endtask

    initial begin
        i_rst_n           = 1'b0;
        i_in_valid        = 1'b0;
        i_command         = CMD_TICK;
        i_display_mode    = MODE_ALL_BLINK;
        i_calib_direction = '0;
        i_mag_step        = '0;
        i_out_stall       = 1'b0;
        i_cfg_valid       = 1'b0;
        i_cfg_index       = CFG_DURATION;
        i_cfg_data        = '0;
        steady            = 1'b0;
        cycles            = 0;
        repeat (5) @(posedge i_clk);
        @(negedge i_clk);
        i_rst_n = 1'b1;

        // Directed part, reset register values.
        // Countdown still zero after reset: the tick drives every pin high.
        send_request(CMD_TICK, MODE_ALL_BLINK, '0, '0);
        // Start ignores mode, direction and step
        send_request(CMD_START, '1, '1, '1);
        send_request(CMD_TICK, MODE_ALL_BLINK, '0, '0);
        // every calibration face, plus the two that blink all channels
        for (int d = 0; d < 2**DIR_W; d++)
            send_request(CMD_TICK, MODE_DIR_CAL, DIR_W'(d), '0);
        // every magnetometer step, step 3 blinks all
        for (int m = 0; m < 2**MAG_W; m++)
            send_request(CMD_TICK, MODE_MAG_CAL, '0, MAG_W'(m));
        send_request(CMD_TICK, MODE_ALL_HIGH, '0, '0);
        // hold modes: pins keep their levels
        for (int m = int'(MODE_ALL_HIGH) + 1; m < 2**MODE_W; m++)
            send_request(CMD_TICK, MODE_W'(m), '1, '1);

        // Countdown expiry: the tick that spends it keeps the level, the next goes high
        wait_drained();
        write_cfg(CFG_DURATION, CFG_DATA_W'(2));
        send_request(CMD_START, MODE_ALL_BLINK, '0, '0);
        repeat (3) send_request(CMD_TICK, MODE_ALL_BLINK, '0, '0);

        // Random phases, each under its own register settings
        for (int p = 0; p < PHASES; p++) begin
            wait_drained();
            load_settings(p);
            steady = (p == 5);  // one long stretch with no idling on either side
            for (int n = 0; n < ITEMS_PER_PHASE; n++) begin
                // sender holds off mid-phase until every result is back
                if (p == 4 && n == ITEMS_PER_PHASE / 2)
                    wait_drained();
                send_random_request();
            end
        end

        wait_drained();
        if (sb.errors == 0 && sb.pending() == 0)
            $display("*** PASSED ***");
        else
            $display("*** FAILED ***");
        $finish;
    end

endmodule
